### hdl/tbr_pkg.sv
// shared types and constants for the timebase rescaler
package tbr_pkg;

  localparam int TICK_WIDTH = 64;
  localparam int BASE_W     = 32;
  localparam int MAG_W      = BASE_W - 1;          // positive timebase value bits
  localparam int MULT_W     = 2 * MAG_W;           // product of two timebase values
  localparam int PROD_W     = TICK_WIDTH + MULT_W; // full numerator width
  localparam int QUO_W      = TICK_WIDTH - 1;      // quotient bits below the clip point
  localparam int HALF_W     = TICK_WIDTH / 2;
  localparam int HIGH_W     = TICK_WIDTH - HALF_W;
  localparam int IN_W       = 64 + 4 * BASE_W;
  localparam int OUT_W      = 64;
  localparam int USER_W     = 2;

  // item inside the divider stages
  typedef struct packed {
    logic              ok;
    logic              neg;
    logic              sat;
    logic [MULT_W-1:0] div;
    logic [MULT_W-1:0] rem;
    logic [QUO_W-1:0]  low;
    logic [QUO_W-1:0]  quo;
  } tbr_div_t;

endpackage

### hdl/tbr_front.sv
// decode, magnitude, multiply and divider setup stages
module tbr_front
  import tbr_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [IN_W-1:0] data_i,
  output logic            valid_o,
  output tbr_div_t        item_o
);

  logic [TICK_WIDTH-1:0] ticks;
  logic [BASE_W-1:0]     sn, sd, dn, dd;
  logic                  ok;

  assign ticks = data_i[TICK_WIDTH-1:0];
  assign sn    = data_i[64 +: BASE_W];
  assign sd    = data_i[64 + BASE_W +: BASE_W];
  assign dn    = data_i[64 + 2 * BASE_W +: BASE_W];
  assign dd    = data_i[64 + 3 * BASE_W +: BASE_W];
  assign ok    = !sn[BASE_W-1] && (|sn) && !sd[BASE_W-1] && (|sd) &&
                 !dn[BASE_W-1] && (|dn) && !dd[BASE_W-1] && (|dd);

  // stage a: validity, magnitude and timebase products
  logic                  a_v_q;
  logic                  a_ok_q, a_neg_q;
  logic [TICK_WIDTH-1:0] a_mag_q;
  logic [MULT_W-1:0]     a_mult_q, a_div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_ok_q   <= ok;
      a_neg_q  <= ticks[TICK_WIDTH-1];
      a_mag_q  <= ticks[TICK_WIDTH-1] ? (~ticks + 1'b1) : ticks;
      a_mult_q <= sn[MAG_W-1:0] * dd[MAG_W-1:0];
      a_div_q  <= sd[MAG_W-1:0] * dn[MAG_W-1:0];
    end
  end

  // stage b: partial products of magnitude and multiplier
  logic                     b_v_q, b_ok_q, b_neg_q;
  logic [MULT_W-1:0]        b_div_q;
  logic [HALF_W+MAG_W-1:0]  b_pp00_q, b_pp01_q;
  logic [HIGH_W+MAG_W-1:0]  b_pp10_q, b_pp11_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en_i) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_ok_q   <= a_ok_q && (|a_div_q);
      b_neg_q  <= a_neg_q;
      b_div_q  <= a_div_q;
      b_pp00_q <= a_mag_q[HALF_W-1:0] * a_mult_q[MAG_W-1:0];
      b_pp01_q <= a_mag_q[HALF_W-1:0] * a_mult_q[MULT_W-1:MAG_W];
      b_pp10_q <= a_mag_q[TICK_WIDTH-1:HALF_W] * a_mult_q[MAG_W-1:0];
      b_pp11_q <= a_mag_q[TICK_WIDTH-1:HALF_W] * a_mult_q[MULT_W-1:MAG_W];
    end
  end

  // stage c: sum of partial products
  logic              c_v_q, c_ok_q, c_neg_q;
  logic [MULT_W-1:0] c_div_q;
  logic [PROD_W-1:0] c_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en_i) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_ok_q   <= b_ok_q;
      c_neg_q  <= b_neg_q;
      c_div_q  <= b_div_q;
      c_prod_q <= PROD_W'(b_pp00_q)
                + (PROD_W'(b_pp01_q) << MAG_W)
                + (PROD_W'(b_pp10_q) << HALF_W)
                + (PROD_W'(b_pp11_q) << (HALF_W + MAG_W));
    end
  end

  // stage d: early clip check on the top bits, divider setup
  logic [PROD_W-QUO_W-1:0] top;
  logic                    big;
  tbr_div_t                d_q;
  logic                    d_v_q;

  assign top = c_prod_q[PROD_W-1:QUO_W];
  assign big = top >= (PROD_W-QUO_W)'(c_div_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (en_i) begin
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q.ok  <= c_ok_q;
      d_q.neg <= c_neg_q;
      d_q.sat <= big;
      d_q.div <= c_div_q;
      d_q.rem <= big ? '0 : top[MULT_W-1:0];
      d_q.low <= c_prod_q[QUO_W-1:0];
      d_q.quo <= '0;
    end
  end

  assign valid_o = d_v_q;
  assign item_o  = d_q;

endmodule

### hdl/tbr_div.sv
// restoring divider, one quotient bit per pipeline stage
module tbr_div
  import tbr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  tbr_div_t item_i,
  output logic     valid_o,
  output tbr_div_t item_o
);

  tbr_div_t stage_q [QUO_W];
  logic     v_q     [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    tbr_div_t        cur;
    logic            cur_v;
    logic [MULT_W:0] trial;
    logic            ge;
    tbr_div_t        nxt;

    // stage input: divider input for the first step, previous stage otherwise
    if (j == 0) begin : g_first
      assign cur   = item_i;
      assign cur_v = valid_i;
    end else begin : g_next
      assign cur   = stage_q[j-1];
      assign cur_v = v_q[j-1];
    end

    // shift in the next numerator bit and try to subtract
    always_comb begin
      trial   = {cur.rem, cur.low[QUO_W-1]};
      ge      = trial >= {1'b0, cur.div};
      nxt     = cur;
      nxt.rem = ge ? MULT_W'(trial - {1'b0, cur.div}) : trial[MULT_W-1:0];
      nxt.low = {cur.low[QUO_W-2:0], 1'b0};
      nxt.quo = {cur.quo[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= cur_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[j] <= nxt;
      end
    end
  end

  assign valid_o = v_q[QUO_W-1];
  assign item_o  = stage_q[QUO_W-1];

endmodule

### hdl/timebase_rescale.sv
// timebase rescaler top level: front end, divider and output register
// an input beat passes front end stages a to d, the divider stages and the output register
// throughput: one beat per cycle unless the output stalls, set by the one-bit-per-stage divider pipeline
// the whole pipeline advances together and holds while the output beat waits
// reset clears all stage valid bits; payload registers are not reset
module timebase_rescale
  import tbr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // src_ticks[63:0], src_num[95:64], src_den[127:96], dst_num[159:128], dst_den[191:160]
  input  logic [IN_W-1:0]   s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // out_ticks[63:0]
  output logic [OUT_W-1:0]  m_axis_tdata,
  // out_valid[0], out_saturated[1]
  output logic [USER_W-1:0] m_axis_tuser
);

  localparam logic [QUO_W-1:0] MaxMag = '1;

  logic     en;
  logic     f_v, d_v;
  tbr_div_t f_item, d_item;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  tbr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .data_i  (s_axis_tdata),
    .valid_o (f_v),
    .item_o  (f_item)
  );

  tbr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_v),
    .item_i  (f_item),
    .valid_o (d_v),
    .item_o  (d_item)
  );

  // clip and sign restore
  logic                  sat;
  logic [QUO_W-1:0]      qv;
  logic [TICK_WIDTH-1:0] res;

  always_comb begin
    sat = d_item.sat || (d_item.quo == MaxMag && (|d_item.rem));
    qv  = sat ? MaxMag : d_item.quo;
    res = d_item.neg ? (~{1'b0, qv} + 1'b1) : {1'b0, qv};
  end

  // output register with invalid masking
  logic                 out_v_q;
  logic [OUT_W-1:0]     out_data_q;
  logic [USER_W-1:0]    out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= d_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= d_item.ok ? OUT_W'(signed'(res)) : '0;
      out_user_q <= d_item.ok ? {sat, 1'b1} : '0;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

### bench/testbench.sv
// self-checking testbench for the timebase rescaler
module testbench;
  import tbr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 68;
  localparam int N_RANDOM    = 1650;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] dst_den;
    logic [31:0] dst_num;
    logic [31:0] src_den;
    logic [31:0] src_num;
    logic [63:0] src_ticks;
  } rescale_req_t;

  typedef struct packed {
    logic [63:0] ticks;
    logic        valid;
    logic        sat;
  } rescale_res_t;

  // directed row: request plus optional hand-written answer
  typedef struct {
    rescale_req_t req;
    bit           known;
    rescale_res_t res;
  } directed_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic [USER_W-1:0] m_axis_tuser;

  rescale_res_t expected_q[$];
  int unsigned  mismatches;
  longint       cycles;
  bit           rx_hold;
  bit           quiet;

  timebase_rescale dut (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // cycle counter and timeout
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // exact rescale: |ticks| * sn * dd / (sd * dn), clipped and sign restored
  function automatic rescale_res_t rescale(rescale_req_t r);
    rescale_res_t o;
    logic [127:0] prod, quo, dvs;
    logic [63:0]  mag, maxmag;
    logic         neg;
    o = '0;
    if ($signed(r.src_num) <= 0 || $signed(r.src_den) <= 0 ||
        $signed(r.dst_num) <= 0 || $signed(r.dst_den) <= 0) return o;
    maxmag = 64'h7fff_ffff_ffff_ffff;
    neg = r.src_ticks[63];
    mag = neg ? -r.src_ticks : r.src_ticks;
    prod = 128'(mag) * 128'(r.src_num) * 128'(r.dst_den);
    dvs = 128'(r.src_den) * 128'(r.dst_num);
    quo = prod / dvs;
    o.valid = 1'b1;
    // clip when the exact quotient lies beyond the largest magnitude
    o.sat = prod > 128'(maxmag) * dvs;
    o.ticks = o.sat ? maxmag : quo[63:0];
    if (neg) o.ticks = -o.ticks;
    return o;
  endfunction

  task automatic report(string what, rescale_res_t got, rescale_res_t exp_r);
    mismatches++;
    $display("mismatch %s at cycle %0d: got %h/%b/%b exp %h/%b/%b", what, cycles,
             got.ticks, got.valid, got.sat, exp_r.ticks, exp_r.valid, exp_r.sat);
  endtask

  task automatic send(rescale_req_t r);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r;
    expected_q.push_back(rescale(r));
    do @(posedge clk_i); while (!s_axis_tready);
    if (!quiet) begin
      while ($urandom_range(99) < 35) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  function automatic logic [31:0] rand_base();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(3);
      3: return $urandom_range(1000, 1);
      default: return $urandom_range(32'h7fff_ffff, 1);
    endcase
  endfunction

  function automatic logic [63:0] rand_ticks();
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return 64'($signed($urandom_range(100000)) - 50000);
      2: return {32'($signed($urandom) >>> 31), $urandom};
      3: return $urandom_range(1) ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      default: return {$urandom_range(1) ? 32'hffff_ffff : 32'h0, $urandom} >>> 0;
    endcase
  endfunction

  // output checker: compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    rescale_res_t got, exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]};
      if (expected_q.size() == 0) begin
        report("unexpected beat", got, '0);
      end else begin
        exp_r = expected_q.pop_front();
        if (got.ticks !== exp_r.ticks) report("ticks", got, exp_r);
        if (got.valid !== exp_r.valid) report("valid", got, exp_r);
        if (got.sat !== exp_r.sat)     report("saturated", got, exp_r);
      end
    end
  end

  // receiver: random stalls, long hold-off window, quiet window
  initial begin
    int unsigned n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
        for (n = 0; n < 200; n++) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 35);
    end
  end

  // stimulus
  initial begin
    directed_row_t rows[$];
    rescale_req_t  r;
    int unsigned   i, w;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    mismatches    = 0;
    rx_hold       = 1'b0;
    quiet         = 1'b0;
    rst_ni        = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    rows.push_back('{'{32'd1, 32'd1, 32'd1, 32'd1, 64'd123}, 1, '{64'd123, 1, 0}});
    rows.push_back('{'{32'd1, 32'd1, 32'd1, 32'd0, 64'd5}, 1, '{64'd0, 0, 0}});
    rows.push_back('{'{32'd1, 32'd1, 32'hffff_ffff, 32'd1, 64'd5}, 1, '{64'd0, 0, 0}});
    rows.push_back('{'{32'd1, 32'd0, 32'd1, 32'd1, 64'd5}, 1, '{64'd0, 0, 0}});
    rows.push_back('{'{32'h8000_0000, 32'd1, 32'd1, 32'd1, 64'd5}, 1, '{64'd0, 0, 0}});
    rows.push_back('{'{32'd1, 32'd1, 32'd1, 32'd1, 64'h8000_0000_0000_0000}, 1,
                     '{64'h8000_0000_0000_0001, 1, 1}});
    rows.push_back('{'{32'd1, 32'd1, 32'd1, 32'd1, 64'h7fff_ffff_ffff_ffff}, 1,
                     '{64'h7fff_ffff_ffff_ffff, 1, 0}});
    rows.push_back('{'{32'd1, 32'd1, 32'd1, 32'd1, 64'hffff_ffff_ffff_ffff}, 1,
                     '{64'hffff_ffff_ffff_ffff, 1, 0}});
    rows.push_back('{'{32'd1, 32'd1, 32'd1, 32'd2, 64'h7fff_ffff_ffff_ffff}, 1,
                     '{64'h7fff_ffff_ffff_ffff, 1, 1}});
    rows.push_back('{'{32'd1, 32'd1, 32'd1, 32'd2, 64'h8000_0000_0000_0001}, 1,
                     '{64'h8000_0000_0000_0001, 1, 1}});
    rows.push_back('{'{32'd1, 32'd1, 32'd1, 32'd1, 64'd0}, 1, '{64'd0, 1, 0}});
    rows.push_back('{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                       64'h7fff_ffff_ffff_ffff}, 0, '0});
    rows.push_back('{'{32'h7fff_ffff, 32'd1, 32'd1, 32'h7fff_ffff, 64'd3}, 0, '0});
    rows.push_back('{'{32'd1, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1, 64'hffff_ffff_ffff_fff0},
                     0, '0});
    rows.push_back('{'{32'd3, 32'd7, 32'd2, 32'd5, 64'hffff_ffff_ffff_ff9c}, 0, '0});
    rows.push_back('{'{32'd90000, 32'd1, 32'd1000, 32'd1, 64'd123456789}, 0, '0});
    foreach (rows[k]) begin
      if (rows[k].known && rescale(rows[k].req) !== rows[k].res)
        report("directed row", rescale(rows[k].req), rows[k].res);
      send(rows[k].req);
    end

    // random part with a receiver hold-off and a quiet stretch
    for (i = 0; i < N_RANDOM; i++) begin
      if (i == 300) rx_hold = 1'b1;
      quiet = (i >= 800 && i < 1000);
      r.src_ticks = rand_ticks();
      r.src_num   = rand_base();
      r.src_den   = rand_base();
      r.dst_num   = rand_base();
      r.dst_den   = rand_base();
      send(r);
    end
    s_axis_tvalid <= 1'b0;
    quiet = 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    for (w = 0; w < 2 * LATENCY; w++) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
